// ----- rtl/core/gra_pkg.sv -----
// ----------------------------------------------------------------------------
// gra_pkg
// Shared widths, register indexes and controller/datapath interface types for
// the greedy round-trip slot allocator.
// ----------------------------------------------------------------------------
package gra_pkg;

    // Field widths
    localparam int CFG_W    = 13;   // configuration data
    localparam int CIDX_W   = 2;    // configuration register index
    localparam int LD_W     = 15;   // link delay
    localparam int SLOT_W   = 12;   // start / return slot on the result
    localparam int RT_W     = LD_W + 1; // round-trip offset, 2 * link delay

    // Default depth of the occupancy maps
    localparam int MAX_PERIOD_DEF = 4096;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_PERIOD   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_MSG_SIZE = 2'd1;

    // Register reset values
    localparam logic [CFG_W-1:0] PERIOD_RST   = 13'd4096;
    localparam logic [CFG_W-1:0] MSG_SIZE_RST = 13'd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;      // latch the round trip of an accepted transaction
        logic div_step;     // one bit of round trip mod period
        logic search_init;  // load the four scan pointers
        logic search_step;  // read the maps at the scan pointers and advance
        logic mark_load;    // take the hit as result, set up the marking
        logic mark_step;    // mark one forward and one return slot
        logic clr_step;     // zero one entry of both maps
        logic res_fail;     // result is "not placed"
        logic out_load;     // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_last;     // final division bit this cycle
        logic hit;          // the evaluated start is free
        logic scan_fail;    // last start evaluated without a hit
        logic mark_last;    // final slot marked this cycle
        logic clr_last;     // final map entry cleared this cycle
    } t_sts;

endpackage

// ----- rtl/core/greedy_round_trip_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// greedy_round_trip_slot_allocator
// Places routes greedily into forward and return occupancy maps over a cyclic
// period; one result transaction for every input transaction.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  input    | in        | i_valid / o_stall    | i_new_instance, i_link_delay
//  result   | out       | o_valid / i_stall    | o_placed, o_fwd_slot,
//           |           |                      | o_ret_slot
//  config   | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_wdata
//
// A transaction runs the round trip mod period divider, then scans up to
// period starts (one candidate per cycle on two read ports of each map), then,
// when the route is placed, marks the message length (one slot marked per
// cycle); new_instance first clears both maps. A failed instance answers
// without dividing or scanning.
// After reset both maps are cleared with o_stall high; configuration writes are
// taken throughout. A waiting result does not block acceptance of the next
// transaction.
// ----------------------------------------------------------------------------
module greedy_round_trip_slot_allocator #(
    parameter int MAX_PERIOD = gra_pkg::MAX_PERIOD_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_new_instance,
    input  logic [gra_pkg::LD_W-1:0]     i_link_delay,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_placed,
    output logic [gra_pkg::SLOT_W-1:0]   o_fwd_slot,
    output logic [gra_pkg::SLOT_W-1:0]   o_ret_slot,
    // configuration channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [gra_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [gra_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import gra_pkg::*;

    localparam int AW = $clog2(MAX_PERIOD);
    localparam int PW = AW + 1;
    localparam int WW = (PW > CFG_W) ? PW : CFG_W;

    logic [CFG_W-1:0] r_period;
    logic [CFG_W-1:0] r_msg_size;
    logic [WW-1:0]    per_w, msg_w, p_w, m_w;
    logic [PW-1:0]    period_eff, msg_eff;
    logic [AW-1:0]    fwd_slot, ret_slot;
    t_cmd             cmd;
    t_sts             sts;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= PERIOD_RST;
            r_msg_size <= MSG_SIZE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_PERIOD:   r_period   <= i_cfg_wdata;
                REG_MSG_SIZE: r_msg_size <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective period (1..MAX_PERIOD) and message size (1..period)
    assign per_w = WW'(r_period);
    assign msg_w = WW'(r_msg_size);

    always_comb begin
        if (per_w == '0) begin
            p_w = WW'(1);
        end else if (per_w > WW'(MAX_PERIOD)) begin
            p_w = WW'(MAX_PERIOD);
        end else begin
            p_w = per_w;
        end
        if (msg_w == '0) begin
            m_w = WW'(1);
        end else if (msg_w > p_w) begin
            m_w = p_w;
        end else begin
            m_w = msg_w;
        end
    end

    assign period_eff = PW'(p_w);
    assign msg_eff    = PW'(m_w);

    gra_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_new_instance (i_new_instance),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_cmd          (cmd),
        .i_sts          (sts)
    );

    gra_dpath #(
        .MAX_PERIOD (MAX_PERIOD)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_link_delay  (i_link_delay),
        .i_period      (period_eff),
        .i_msg_size    (msg_eff),
        .o_placed      (o_placed),
        .o_fwd_slot    (fwd_slot),
        .o_ret_slot    (ret_slot)
    );

    assign o_fwd_slot = SLOT_W'(fwd_slot);
    assign o_ret_slot = SLOT_W'(ret_slot);

endmodule

// ----- rtl/core/gra_ctrl.sv -----
// ----------------------------------------------------------------------------
// gra_ctrl
// Sequencer for the slot allocator: clearing pass, modulo division, scan,
// marking and result hand-off. Holds the instance failure flag and the
// output valid.
// ----------------------------------------------------------------------------
module gra_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_new_instance,
    output logic          o_valid,
    input  logic          i_stall,
    output gra_pkg::t_cmd o_cmd,
    input  gra_pkg::t_sts i_sts
);
    import gra_pkg::*;

    localparam logic [2:0] ST_BOOT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_CLEAR  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_SINIT  = 3'd4;
    localparam logic [2:0] ST_SEARCH = 3'd5;
    localparam logic [2:0] ST_MARK   = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_failed, n_failed;
    logic       r_out_vld, n_out_vld;
    logic       in_acc;
    logic       out_free;
    t_cmd       cmd;

    assign o_stall  = (r_state != ST_IDLE);
    assign in_acc   = i_valid & ~o_stall;
    assign out_free = ~r_out_vld | ~i_stall;
    assign o_valid  = r_out_vld;
    assign o_cmd    = cmd;

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_failed = r_failed;
        cmd      = '0;
        unique case (r_state)
            ST_BOOT: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc) begin
                    cmd.capture = 1'b1;
                    if (i_new_instance) begin
                        n_failed = 1'b0;
                        n_state  = ST_CLEAR;
                    end else if (r_failed) begin
                        cmd.res_fail = 1'b1;
                        n_state      = ST_DONE;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = ST_SINIT;
            end
            ST_SINIT: begin
                cmd.search_init = 1'b1;
                n_state         = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (i_sts.hit) begin
                    cmd.mark_load = 1'b1;
                    n_state       = ST_MARK;
                end else if (i_sts.scan_fail) begin
                    cmd.res_fail = 1'b1;
                    n_failed     = 1'b1;
                    n_state      = ST_DONE;
                end else begin
                    cmd.search_step = 1'b1;
                end
            end
            ST_MARK: begin
                cmd.mark_step = 1'b1;
                if (i_sts.mark_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output valid: set on load, dropped when the transaction is taken
    always_comb begin
        n_out_vld = r_out_vld;
        if (r_out_vld && !i_stall) n_out_vld = 1'b0;
        if (cmd.out_load)          n_out_vld = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_BOOT;
            r_failed  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_failed  <= n_failed;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

// ----- rtl/core/gra_dpath.sv -----
// ----------------------------------------------------------------------------
// gra_dpath
// Datapath of the slot allocator: forward and return occupancy maps (two
// read ports, one write port each), round trip mod period divider, scan and
// marking pointers, result and output registers.
// ----------------------------------------------------------------------------
module gra_dpath #(
    parameter int MAX_PERIOD = gra_pkg::MAX_PERIOD_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gra_pkg::t_cmd                   i_cmd,
    output gra_pkg::t_sts                   o_sts,
    input  logic [gra_pkg::LD_W-1:0]        i_link_delay,
    input  logic [$clog2(MAX_PERIOD):0]     i_period,
    input  logic [$clog2(MAX_PERIOD):0]     i_msg_size,
    output logic                            o_placed,
    output logic [$clog2(MAX_PERIOD)-1:0]   o_fwd_slot,
    output logic [$clog2(MAX_PERIOD)-1:0]   o_ret_slot
);
    import gra_pkg::*;

    localparam int AW    = $clog2(MAX_PERIOD);
    localparam int PW    = AW + 1;
    localparam int DIV_N = RT_W;
    localparam int DCW   = $clog2(DIV_N);

    // Occupancy maps
    logic r_fwd_mem [MAX_PERIOD];
    logic r_ret_mem [MAX_PERIOD];
    logic r_fwd_q0, r_fwd_q1, r_ret_q0, r_ret_q1;

    // Divider
    logic [RT_W-1:0] r_dvd;
    logic [AW-1:0]   r_rem;
    logic [DCW-1:0]  r_div_cnt;
    logic [PW-1:0]   rem_sh;

    // Scan / mark pointers
    logic [AW-1:0]   r_j, r_fa, r_rs, r_re;
    logic            r_issued_all;
    logic            r_ev_vld, r_ev_last;
    logic [AW-1:0]   r_ev_j, r_ev_rs;
    logic [PW-1:0]   r_mark_cnt;
    logic [AW-1:0]   r_clr_cnt;

    // Result and output
    logic            r_res_placed;
    logic [AW-1:0]   r_res_start, r_res_ret;
    logic            r_out_placed;
    logic [AW-1:0]   r_out_start, r_out_ret;

    logic            j_last;
    logic            issue;
    logic            hit;
    logic [AW:0]     re_sum;
    logic [AW-1:0]   re_init, fa_init;
    logic            map_we;
    logic            map_wd;
    logic [AW-1:0]   fwd_wa, ret_wa;

    // Pointer increment, wrapping at the period
    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x,
                                               input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = {1'b0, x} + PW'(1);
        return (s == p) ? '0 : s[AW-1:0];
    endfunction

    // Restoring division step for round trip mod period
    assign rem_sh = {r_rem, r_dvd[RT_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dvd     <= {i_link_delay, 1'b0};
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd     <= {r_dvd[RT_W-2:0], 1'b0};
            r_rem     <= (rem_sh >= i_period) ? AW'(rem_sh - i_period) : rem_sh[AW-1:0];
            r_div_cnt <= r_div_cnt + DCW'(1);
        end
    end

    // Initial pointers: j+m and j+r+m-1 at j = 0
    assign fa_init = (i_msg_size == i_period) ? '0 : i_msg_size[AW-1:0];
    assign re_sum  = {1'b0, r_rem} + i_msg_size - (AW+1)'(1);
    assign re_init = (re_sum >= i_period) ? AW'(re_sum - i_period) : re_sum[AW-1:0];

    assign j_last = (({1'b0, r_j} + PW'(1)) == i_period);
    assign issue  = i_cmd.search_step & ~r_issued_all;

    // Scan and mark pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.search_init) begin
            r_j  <= '0;
            r_fa <= fa_init;
            r_rs <= r_rem;
            r_re <= re_init;
        end else if (issue) begin
            r_j  <= wrap_inc(r_j, i_period);
            r_fa <= wrap_inc(r_fa, i_period);
            r_rs <= wrap_inc(r_rs, i_period);
            r_re <= wrap_inc(r_re, i_period);
        end else if (i_cmd.mark_load) begin
            r_j        <= r_ev_j;
            r_rs       <= r_ev_rs;
        end else if (i_cmd.mark_step) begin
            r_j  <= wrap_inc(r_j, i_period);
            r_rs <= wrap_inc(r_rs, i_period);
        end
        if (i_cmd.mark_load) begin
            r_mark_cnt <= i_msg_size;
        end else if (i_cmd.mark_step) begin
            r_mark_cnt <= r_mark_cnt - PW'(1);
        end
        if (issue) begin
            r_ev_j    <= r_j;
            r_ev_rs   <= r_rs;
            r_ev_last <= j_last;
        end
    end

    // Scan control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_vld     <= 1'b0;
            r_issued_all <= 1'b0;
            r_clr_cnt    <= '0;
        end else begin
            r_ev_vld <= issue;
            if (i_cmd.search_init) begin
                r_issued_all <= 1'b0;
            end else if (issue && j_last) begin
                r_issued_all <= 1'b1;
            end
            if (i_cmd.clr_step) begin
                r_clr_cnt <= (r_clr_cnt == AW'(MAX_PERIOD - 1)) ? '0 : r_clr_cnt + AW'(1);
            end
        end
    end

    // Map write port: clearing pass or marking
    assign map_we = i_cmd.clr_step | i_cmd.mark_step;
    assign map_wd = ~i_cmd.clr_step;
    assign fwd_wa = i_cmd.clr_step ? r_clr_cnt : r_j;
    assign ret_wa = i_cmd.clr_step ? r_clr_cnt : r_rs;

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_fwd_mem[fwd_wa] <= map_wd;
        end
        r_fwd_q0 <= r_fwd_mem[r_j];
        r_fwd_q1 <= r_fwd_mem[r_fa];
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_ret_mem[ret_wa] <= map_wd;
        end
        r_ret_q0 <= r_ret_mem[r_rs];
        r_ret_q1 <= r_ret_mem[r_re];
    end

    // Evaluation of the candidate read last cycle
    assign hit = r_ev_vld & ~r_fwd_q0 & ~r_fwd_q1 & ~r_ret_q0 & ~r_ret_q1;

    // Result and output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mark_load) begin
            r_res_placed <= 1'b1;
            r_res_start  <= r_ev_j;
            r_res_ret    <= r_ev_rs;
        end else if (i_cmd.res_fail) begin
            r_res_placed <= 1'b0;
            r_res_start  <= '0;
            r_res_ret    <= '0;
        end
        if (i_cmd.out_load) begin
            r_out_placed <= r_res_placed;
            r_out_start  <= r_res_start;
            r_out_ret    <= r_res_ret;
        end
    end

    assign o_sts.div_last  = i_cmd.div_step & (r_div_cnt == DCW'(DIV_N - 1));
    assign o_sts.hit       = hit;
    assign o_sts.scan_fail = r_ev_vld & r_ev_last & ~hit;
    assign o_sts.mark_last = i_cmd.mark_step & (r_mark_cnt == PW'(1));
    assign o_sts.clr_last  = i_cmd.clr_step & (r_clr_cnt == AW'(MAX_PERIOD - 1));

    assign o_placed   = r_out_placed;
    assign o_fwd_slot = r_out_start;
    assign o_ret_slot = r_out_ret;

endmodule

// ----- tb/sv/tb_greedy_round_trip_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_greedy_round_trip_slot_allocator
// Self-checking testbench for the greedy round-trip slot allocator. A queue-fed
// driver sends route transactions in bursts and a monitor checks every result
// transaction against a cycle-free predictor of the two occupancy maps. A
// directed part covers delay extremes, failing and failed instances,
// saturated and zero registers and a period change mid-instance. A random
// part then runs many register settings, with the receiver stalling on a
// pattern of its own.
// ----------------------------------------------------------------------------
module tb_greedy_round_trip_slot_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import gra_pkg::*;

    // Register indexes that decode to nothing
    localparam logic [CIDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CIDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam int RANDOM_ROUTES = 120;
    localparam int DRAIN_CYCLES  = 200;
    localparam longint unsigned RUN_LIMIT_NS = 64'd100_000_000;

    typedef struct {
        logic               new_inst;
        logic [LD_W-1:0]    delay;
    } route_item_t;

    typedef struct packed {
        logic               placed;
        logic [SLOT_W-1:0]  start;
        logic [SLOT_W-1:0]  ret;
    } route_res_t;

    typedef struct {
        logic [CIDX_W-1:0]  idx;
        logic [CFG_W-1:0]   data;
    } cfg_write_t;

    typedef enum int {RX_FREE, RX_SPARSE, RX_PERIODIC, RX_HEAVY} rx_mode_e;

    // DUT ports, inputs known from time zero
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic                o_stall;
    logic                i_new_instance = 1'b0;
    logic [LD_W-1:0]     i_link_delay   = '0;
    logic                o_valid;
    logic                i_stall        = 1'b0;
    logic                o_placed;
    logic [SLOT_W-1:0]   o_fwd_slot;
    logic [SLOT_W-1:0]   o_ret_slot;
    logic                i_cfg_valid    = 1'b0;
    logic                o_cfg_ready;
    logic [CIDX_W-1:0]   i_cfg_index    = '0;
    logic [CFG_W-1:0]    i_cfg_wdata    = '0;

    // Predictor state
    logic [MAX_PERIOD_DEF-1:0] fwd_busy     = '0;
    logic [MAX_PERIOD_DEF-1:0] ret_busy     = '0;
    logic                      inst_failed  = 1'b0;
    logic [CFG_W-1:0]          cfg_period   = PERIOD_RST;
    logic [CFG_W-1:0]          cfg_msg_size = MSG_SIZE_RST;

    // Pending stimulus and expected results
    route_item_t pending_routes[$];
    cfg_write_t  pending_writes[$];
    route_res_t  expected_routes[$];

    // Driver and receiver pacing
    int       burst_left = 1;
    int       gap_left   = 0;
    rx_mode_e stall_mode = RX_FREE;
    int       stall_span = 0;

    // Bookkeeping
    int mismatch_count = 0;
    int routes_sent    = 0;
    int routes_checked = 0;
    int routes_placed  = 0;
    int cfg_writes     = 0;
    int settings_run   = 0;
    int random_routes  = 0;

    greedy_round_trip_slot_allocator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_new_instance (i_new_instance),
        .i_link_delay   (i_link_delay),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_placed       (o_placed),
        .o_fwd_slot     (o_fwd_slot),
        .o_ret_slot     (o_ret_slot),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Greedy placement of one route into the predicted maps
    function automatic route_res_t place_route(input logic new_inst,
                                               input logic [LD_W-1:0] delay);
        int unsigned p, m, r, j, k, rs;
        logic        found;
        route_res_t  res;
        p = 32'(cfg_period);
        if (p == 0) p = 1;
        if (p > MAX_PERIOD_DEF) p = MAX_PERIOD_DEF;
        m = 32'(cfg_msg_size);
        if (m == 0) m = 1;
        if (m > p) m = p;
        res   = '0;
        found = 1'b0;
        if (new_inst) begin
            fwd_busy    = '0;
            ret_busy    = '0;
            inst_failed = 1'b0;
        end
        r = 32'({delay, 1'b0});
        if (!inst_failed) begin
            for (j = 0; j < p && !found; j++) begin
                rs = (j + r) % p;
                if (!fwd_busy[j] && !fwd_busy[(j + m) % p] &&
                    !ret_busy[rs] && !ret_busy[(j + r + m - 1) % p]) begin
                    for (k = 0; k < m; k++) begin
                        fwd_busy[(j + k) % p]  = 1'b1;
                        ret_busy[(rs + k) % p] = 1'b1;
                    end
                    res.placed = 1'b1;
                    res.start  = SLOT_W'(j);
                    res.ret    = SLOT_W'(rs);
                    found      = 1'b1;
                end
            end
            if (!found) inst_failed = 1'b1;
        end
        return res;
    endfunction

    // One line per mismatch
    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatch_count++;
    endtask

    // Route driver: bursts with random gaps, holds a stalled transaction
    always @(posedge i_clk) begin : route_driver
        logic taken;
        taken = i_valid && !o_stall;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (taken) begin
                expected_routes.push_back(place_route(i_new_instance, i_link_delay));
                void'(pending_routes.pop_front());
                routes_sent++;
            end
            if (!i_valid || taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_routes.size() > 0) begin
                    i_valid        <= 1'b1;
                    i_new_instance <= pending_routes[0].new_inst;
                    i_link_delay   <= pending_routes[0].delay;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 8);
                        case ($urandom_range(0, 7))
                            0, 1, 2: gap_left = 0;
                            7:       gap_left = $urandom_range(20, 60);
                            default: gap_left = $urandom_range(1, 6);
                        endcase
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Register write driver; the predictor's copy follows each accepted write
    always @(posedge i_clk) begin : cfg_driver
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_PERIOD:   cfg_period   = i_cfg_wdata;
                    REG_MSG_SIZE: cfg_msg_size = i_cfg_wdata;
                    default:      ;
                endcase
                void'(pending_writes.pop_front());
                cfg_writes++;
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (pending_writes.size() > 0) begin
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= pending_writes[0].idx;
                    i_cfg_wdata <= pending_writes[0].data;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern: modes held for random spans
    always @(posedge i_clk) begin : rx_stall
        logic stall_now;
        stall_now = 1'b0;
        if (stall_span == 0) begin
            stall_mode = rx_mode_e'($urandom_range(0, 3));
            stall_span = $urandom_range(40, 400);
        end else begin
            stall_span--;
        end
        case (stall_mode)
            RX_FREE:     stall_now = 1'b0;
            RX_SPARSE:   stall_now = ($urandom_range(0, 3) == 0);
            RX_PERIODIC: stall_now = ((stall_span % 16) < 12);
            RX_HEAVY:    stall_now = ($urandom_range(0, 3) != 0);
            default:     stall_now = 1'b0;
        endcase
        if (!i_rst_n) i_stall <= 1'b0;
        else          i_stall <= stall_now;
    end

    // Result monitor: oldest expectation against each accepted result
    always @(posedge i_clk) begin : result_monitor
        route_res_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_routes.size() == 0) begin
                report_mismatch($sformatf(
                    "result transaction with no route pending: placed=%0b start=%0d ret=%0d",
                    o_placed, o_fwd_slot, o_ret_slot));
            end else begin
                want = expected_routes.pop_front();
                if (o_placed !== want.placed)
                    report_mismatch($sformatf("route %0d placed: got %0b want %0b",
                                              routes_checked, o_placed, want.placed));
                if (o_fwd_slot !== want.start)
                    report_mismatch($sformatf("route %0d forward slot: got %0d want %0d",
                                              routes_checked, o_fwd_slot, want.start));
                if (o_ret_slot !== want.ret)
                    report_mismatch($sformatf("route %0d return slot: got %0d want %0d",
                                              routes_checked, o_ret_slot, want.ret));
                if (want.placed) routes_placed++;
            end
            routes_checked++;
        end
    end

    task automatic add_route(input logic ni, input logic [LD_W-1:0] d);
        route_item_t item;
        item.new_inst = ni;
        item.delay    = d;
        pending_routes.push_back(item);
    endtask

    task automatic push_write(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write_t wr;
        wr.idx  = idx;
        wr.data = data;
        pending_writes.push_back(wr);
    endtask

    // Block idle: nothing queued, nothing in flight, nothing owed
    task automatic wait_idle();
        while (pending_routes.size() != 0 || i_valid || expected_routes.size() != 0 ||
               pending_writes.size() != 0 || i_cfg_valid)
            @(negedge i_clk);
    endtask

    // New register setting, written only once the block is idle
    task automatic set_config(input logic [CFG_W-1:0] p, input logic [CFG_W-1:0] m);
        wait_idle();
        if ($urandom_range(0, 1)) begin
            push_write(REG_PERIOD, p);
            push_write(REG_MSG_SIZE, m);
        end else begin
            push_write(REG_MSG_SIZE, m);
            push_write(REG_PERIOD, p);
        end
        if ($urandom_range(0, 2) == 0)
            push_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                       CFG_W'($urandom_range(0, 8191)));
        while (pending_writes.size() != 0 || i_cfg_valid) @(negedge i_clk);
        settings_run++;
    endtask

    // One random register setting followed by instances of routes
    task automatic random_phase();
        int unsigned p, peff, m, n, left, inst_len, i, d;
        logic        ni, first;
        case ($urandom_range(0, 9))
            6:       p = $urandom_range(49, 600);
            7:       p = 0;
            8:       p = 4096;
            9:       p = $urandom_range(4097, 8191);
            default: p = $urandom_range(1, 48);
        endcase
        peff = (p == 0) ? 1 : ((p > MAX_PERIOD_DEF) ? MAX_PERIOD_DEF : p);
        case ($urandom_range(0, 7))
            0:       m = 0;
            1:       m = p;
            2:       m = $urandom_range(0, 8191);
            default: m = $urandom_range(1, (peff > 3) ? peff / 3 : 1);
        endcase
        // large periods are slow: keep those phases short
        n = (peff > 600) ? $urandom_range(2, 4) : $urandom_range(8, 20);
        set_config(CFG_W'(p), CFG_W'(m));
        left  = n;
        first = 1'b1;
        while (left > 0) begin
            inst_len = $urandom_range(1, 8);
            for (i = 0; i < inst_len && left > 0; i++) begin
                ni = (i == 0);
                // sometimes keep the old maps across the new setting
                if (i == 0 && first && $urandom_range(0, 3) == 0) ni = 1'b0;
                if ($urandom_range(0, 9) == 0) ni = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 15))
                    0:          d = 0;
                    1:          d = 32767;
                    2, 3, 4, 5: d = $urandom_range(0, 32767);
                    default:    d = $urandom_range(0, 2 * peff);
                endcase
                add_route(ni, LD_W'(d));
                left--;
                random_routes++;
            end
            first = 1'b0;
        end
    endtask

    // Stimulus and end of run
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setting, delay extremes
        add_route(1'b0, 15'd0);
        add_route(1'b0, 15'h7FFF);
        add_route(1'b1, 15'h7FFF);

        // small period: fill until the instance fails, then recover
        set_config(13'd4, 13'd2);
        add_route(1'b1, 15'd1);
        add_route(1'b0, 15'd1);
        add_route(1'b0, 15'd0);
        add_route(1'b1, 15'd5);
        add_route(1'b0, 15'd3);

        // period widened mid-instance, old maps kept
        set_config(13'd8, 13'd2);
        add_route(1'b0, 15'd1);
        add_route(1'b0, 15'd2);

        // zero period and zero message size, plus writes to spare indexes
        set_config(13'd0, 13'd0);
        wait_idle();
        push_write(REG_SPARE_LO, 13'h1FFF);
        push_write(REG_SPARE_HI, 13'd0);
        wait_idle();
        add_route(1'b1, 15'd0);
        add_route(1'b0, 15'd7);

        // message larger than the period fills it whole
        set_config(13'd5, 13'h1FFF);
        add_route(1'b1, 15'd3);
        add_route(1'b0, 15'd0);

        // period beyond the map depth saturates
        set_config(13'h1FFF, 13'd4096);
        add_route(1'b1, 15'd16383);
        add_route(1'b0, 15'd1);

        while (random_routes < RANDOM_ROUTES) random_phase();

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Covered %0d routes (%0d placed, %0d refused) over %0d register settings.",
                 routes_checked, routes_placed, routes_checked - routes_placed,
                 settings_run);
        $display("Register writes: %0d, mismatches: %0d.", cfg_writes, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout with %0d results still owed", expected_routes.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/gra_pkg.sv
rtl/core/gra_ctrl.sv
rtl/core/gra_dpath.sv
rtl/core/greedy_round_trip_slot_allocator.sv
tb/sv/tb_greedy_round_trip_slot_allocator.sv
